### hw/rtl/wssl_pkg.sv
// Shared types and constants for the weekly setpoint schedule lookup.
`timescale 1ns / 1ps

package wssl_pkg;

    localparam int NUM_DAYS       = 7;
    localparam int DAY_W          = 3;
    localparam int SLOT_IN_W      = 3;
    localparam int HOUR_W         = 5;
    localparam int MINUTE_W       = 6;
    localparam int TEMP_W         = 12;
    localparam int COUNT_IN_W     = 4;
    localparam int MOD_W          = 11;   // minute of day, up to 31*60+63
    localparam int MIN_PER_HOUR   = 60;
    localparam logic [DAY_W-1:0] LAST_DAY = DAY_W'(NUM_DAYS - 1);

    typedef enum logic [1:0] {
        ACT_WR_POINT = 2'd0,
        ACT_WR_COUNT = 2'd1,
        ACT_QUERY    = 2'd2,
        ACT_NONE     = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREV,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic signed [TEMP_W-1:0] temperature;
    } point_t;

    typedef struct packed {
        logic                  pt_we;
        logic                  cnt_we;
        logic [DAY_W-1:0]      day;
        logic [SLOT_IN_W-1:0]  slot;
        logic [COUNT_IN_W-1:0] count;
        point_t                point;
    } store_wr_t;

    function automatic logic [MOD_W-1:0] minute_of_day(
        input logic [HOUR_W-1:0]   hour,
        input logic [MINUTE_W-1:0] minute
    );
        logic [MOD_W-1:0] h;
        h = MOD_W'(hour);
        return (h * MOD_W'(MIN_PER_HOUR)) + MOD_W'(minute);
    endfunction

endpackage

### hw/rtl/wssl_point_store.sv
// Point memory and per-day point counts of the schedule.
`timescale 1ns / 1ps

module wssl_point_store
    import wssl_pkg::*;
#(
    parameter int MAX_POINTS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  store_wr_t             wr,
    input  logic                  rd_en,
    input  logic [DAY_W-1:0]      rd_day,
    input  logic [((MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1)-1:0] rd_slot,
    output point_t                rd_data,
    input  logic [DAY_W-1:0]      cnt_rd_day,
    output logic [$clog2(MAX_POINTS + 1)-1:0] cnt_rd
);

    localparam int SLOT_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int ADDR_W = DAY_W + SLOT_W;
    localparam int DEPTH  = 1 << ADDR_W;

    point_t mem [DEPTH];
    point_t rd_data_reg;

    logic [CNT_W-1:0] count_reg [NUM_DAYS];

    logic             wr_day_ok;
    logic             wr_slot_ok;
    logic [CNT_W-1:0] cnt_sat;

    assign wr_day_ok  = (wr.day <= LAST_DAY);
    assign wr_slot_ok = (int'(wr.slot) < MAX_POINTS);
    assign cnt_sat    = (int'(wr.count) > MAX_POINTS) ? CNT_W'(MAX_POINTS) : CNT_W'(wr.count);

    always_ff @(posedge aclk) begin
        if (wr.pt_we && wr_day_ok && wr_slot_ok) begin
            mem[{wr.day, SLOT_W'(wr.slot)}] <= wr.point;
        end
        if (rd_en) begin
            rd_data_reg <= mem[{rd_day, rd_slot}];
        end
    end

    assign rd_data = rd_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int d = 0; d < NUM_DAYS; d++) begin
                count_reg[d] <= '0;
            end
        end else if (wr.cnt_we && wr_day_ok) begin
            count_reg[wr.day] <= cnt_sat;
        end
    end

    // day 7 never reaches a count read during a query; return zero for it
    assign cnt_rd = (cnt_rd_day <= LAST_DAY) ? count_reg[cnt_rd_day] : '0;

endmodule

### hw/rtl/weekly_setpoint_schedule_lookup.sv
// Top level of the weekly setpoint schedule lookup.
`timescale 1ns / 1ps

// Weekly setpoint schedule: 7 days of up to MAX_POINTS points (hour, minute,
// signed temperature in tenths of a degree) plus a per-day point count that is
// cleared at reset and saturates at MAX_POINTS. A request with action 0 writes
// one point, action 1 writes one day's count, action 2 returns one setpoint,
// action 3 is ignored. Write requests give no result. A query is accepted,
// then reads the previous day's last point, then streams today's points through
// the single read port of the point memory at one slot per cycle, and then
// loads the output register once the result channel is free. A query with a day
// above 6 skips the table and returns default_setpoint. The point memory holds
// no reset; only slots below a day's count must have been written. Requests are
// taken only while no query is in progress, so table writes never overlap a
// scan. default_setpoint must be written through cfg_wr_en / cfg_wr_data only
// while idle; the block does not enforce this.

module weekly_setpoint_schedule_lookup
    import wssl_pkg::*;
#(
    parameter int MAX_POINTS = 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // configuration
    input  logic                     cfg_wr_en,
    input  logic signed [TEMP_W-1:0] cfg_wr_data,
    // request channel
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_action,
    input  logic [DAY_W-1:0]         s_day,
    input  logic [SLOT_IN_W-1:0]     s_slot,
    input  logic [HOUR_W-1:0]        s_hour,
    input  logic [MINUTE_W-1:0]      s_minute,
    input  logic signed [TEMP_W-1:0] s_temperature,
    input  logic [COUNT_IN_W-1:0]    s_point_count,
    // result channel
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [TEMP_W-1:0] m_setpoint
);

    localparam int SLOT_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);

    // configuration register
    logic signed [TEMP_W-1:0] default_setpoint_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_setpoint_reg <= TEMP_W'(180);
        end else if (cfg_wr_en) begin
            default_setpoint_reg <= cfg_wr_data;
        end
    end

    // sequencer state
    state_t state_reg, state_next;

    logic [DAY_W-1:0]         day_reg;
    logic [MOD_W-1:0]         now_reg;
    logic [CNT_W-1:0]         idx_reg, idx_next;
    logic signed [TEMP_W-1:0] sp_reg, sp_next;
    logic                     pend_reg, pend_next;       // read data arrives this cycle
    logic                     pend_prev_reg, pend_prev_next; // it is yesterday's last point

    logic                     m_valid_reg, m_valid_next;
    logic signed [TEMP_W-1:0] m_setpoint_reg;

    logic       accept;
    logic       is_query;
    logic       day_ok;
    logic       out_free;
    action_t    action;

    // store interface
    store_wr_t        wr;
    logic             rd_en;
    logic [DAY_W-1:0] rd_day;
    logic [SLOT_W-1:0] rd_slot;
    point_t           rd_data;
    logic [DAY_W-1:0] cnt_rd_day;
    logic [CNT_W-1:0] cnt_rd;
    logic [CNT_W-1:0] cnt_m1;
    logic [DAY_W-1:0] prev_day;
    logic [MOD_W-1:0] pt_min;

    assign action   = action_t'(s_action);
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign is_query = (action == ACT_QUERY);
    assign day_ok   = (s_day <= LAST_DAY);
    assign out_free = !m_valid_reg || m_ready;
    assign prev_day = (day_reg == '0) ? LAST_DAY : (day_reg - DAY_W'(1));
    assign cnt_m1   = cnt_rd - CNT_W'(1);
    assign pt_min   = minute_of_day(rd_data.hour, rd_data.minute);

    // writes land in the store on the accept edge
    always_comb begin
        wr.pt_we             = accept && (action == ACT_WR_POINT);
        wr.cnt_we            = accept && (action == ACT_WR_COUNT);
        wr.day               = s_day;
        wr.slot              = s_slot;
        wr.count             = s_point_count;
        wr.point.hour        = s_hour;
        wr.point.minute      = s_minute;
        wr.point.temperature = s_temperature;
    end

    wssl_point_store #(
        .MAX_POINTS (MAX_POINTS)
    ) u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr         (wr),
        .rd_en      (rd_en),
        .rd_day     (rd_day),
        .rd_slot    (rd_slot),
        .rd_data    (rd_data),
        .cnt_rd_day (cnt_rd_day),
        .cnt_rd     (cnt_rd)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && is_query) begin
                    state_next = day_ok ? ST_PREV : ST_DONE;
                end
            end
            ST_PREV: begin
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (!(idx_reg < cnt_rd)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // memory port control per state
    always_comb begin
        rd_en      = 1'b0;
        rd_day     = day_reg;
        rd_slot    = idx_reg[SLOT_W-1:0];
        cnt_rd_day = day_reg;
        case (state_reg)
            ST_PREV: begin
                // yesterday's last counted point seeds the setpoint
                cnt_rd_day = prev_day;
                rd_day     = prev_day;
                rd_slot    = cnt_m1[SLOT_W-1:0];
                rd_en      = (cnt_rd != '0);
            end
            ST_SCAN: begin
                rd_en = (idx_reg < cnt_rd);
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb begin
        idx_next       = idx_reg;
        sp_next        = sp_reg;
        pend_next      = 1'b0;
        pend_prev_next = 1'b0;
        m_valid_next   = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                idx_next = '0;
                sp_next  = default_setpoint_reg;
            end
            ST_PREV: begin
                pend_next      = rd_en;
                pend_prev_next = 1'b1;
            end
            ST_SCAN: begin
                // slot order is kept, so the last qualifying point wins
                if (pend_reg && (pend_prev_reg || (now_reg >= pt_min))) begin
                    sp_next = rd_data.temperature;
                end
                pend_next = rd_en;
                if (rd_en) begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                idx_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            pend_prev_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            pend_prev_reg <= pend_prev_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        sp_reg  <= sp_next;
        if (accept) begin
            day_reg <= s_day;
            now_reg <= minute_of_day(s_hour, s_minute);
        end
        if ((state_reg == ST_DONE) && out_free) begin
            m_setpoint_reg <= sp_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_setpoint = m_setpoint_reg;

endmodule
